/* hw/rtl/enig_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma rotor cipher package
// Shared types, rotor tables and small mod-26 helper functions.
// ----------------------------------------------------------------------------
package enig_pkg;

   localparam int LETTERS             = 26;
   localparam int TAB_W               = 8 * LETTERS;
   localparam int ROTORS              = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int PLUG_W              = 50;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_ADDR_W          = 6;

   // Opcodes carried in the request tuser.
   localparam logic OP_ENCIPHER = 1'b0;
   localparam logic OP_LOAD     = 1'b1;

   // Register indexes, address = 8 * index.
   localparam logic [2:0] REG_ROTOR_LEFT   = 3'd0;
   localparam logic [2:0] REG_ROTOR_MIDDLE = 3'd1;
   localparam logic [2:0] REG_ROTOR_RIGHT  = 3'd2;
   localparam logic [2:0] REG_RING_LEFT    = 3'd3;
   localparam logic [2:0] REG_RING_MIDDLE  = 3'd4;
   localparam logic [2:0] REG_RING_RIGHT   = 3'd5;
   localparam logic [2:0] REG_PLUG_FIRST   = 3'd6;
   localparam logic [2:0] REG_PLUG_SECOND  = 3'd7;

   // Wiring tables as ASCII strings; the first letter sits in the top byte.
   localparam logic [TAB_W-1:0] REFL_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

   localparam logic [TAB_W-1:0] FWD_WIRING [ROTORS] = '{
      "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
      "AJDKSIRUXBLHWTMCQGZNPYFVOE",
      "BDFHJLCPRTXVZNYEIWGAKMUSQO",
      "ESOVPZJAYQUIRHXLNFTGKDCMWB",
      "VZBRGITYUPSDNHLXAWMJQOFECK"
   };

   localparam logic [TAB_W-1:0] INV_WIRING [ROTORS] = '{
      "UWYGADFPVZBECKMTHXSLRINQOJ",
      "AJPCZWRLFBDKOTYUQGENHXMIVS",
      "TAGBPCSDQEUFVNZHYIXJWLRKOM",
      "HZWVARTNLGUPXQCEJMBSKDYOIF",
      "QCYLXWENFTZOSMVJUDKGIARPHB"
   };

   // Turnover letters R, F, W, K, A for rotors I..V.
   localparam logic [4:0] TURN_AFTER [ROTORS] = '{5'd17, 5'd5, 5'd22, 5'd10, 5'd0};

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [2:0]        rotor_l;
      logic [2:0]        rotor_m;
      logic [2:0]        rotor_r;
      logic [4:0]        ring_l;
      logic [4:0]        ring_m;
      logic [4:0]        ring_r;
      logic [PLUG_W-1:0] plug_lo;
      logic [PLUG_W-1:0] plug_hi;
   } enig_cfg_type;

   // One letter in flight: current value, rotor offsets and windows.
   typedef struct packed {
      logic [4:0] letter;
      logic [4:0] off_l;
      logic [4:0] off_m;
      logic [4:0] off_r;
      logic [4:0] win_l;
      logic [4:0] win_m;
      logic [4:0] win_r;
   } enig_item_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] val;
   } plug_hit_type;

   function automatic logic [4:0] mod26(input logic [4:0] v);
      return (v >= 5'd26) ? 5'(v - 5'd26) : v;
   endfunction

   function automatic logic [4:0] inc26(input logic [4:0] v);
      return (v == 5'd25) ? 5'd0 : 5'(v + 5'd1);
   endfunction

   function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
   endfunction

   function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
      return (a >= b) ? 5'(a - b) : 5'(a + 5'd26 - b);
   endfunction

   function automatic logic [4:0] letter_at(input logic [TAB_W-1:0] tab,
                                            input logic [4:0] idx);
      int         pos;
      logic [7:0] ch;
      pos = 8 * (LETTERS - 1 - int'(idx));
      ch  = tab[pos +: 8];
      return 5'(ch - 8'd65);
   endfunction

   // One rotor pass: enter at offset, look up the wiring, leave at offset.
   function automatic logic [4:0] rotor_pass(input logic [TAB_W-1:0] tab,
                                             input logic [4:0] x,
                                             input logic [4:0] off);
      logic [4:0] y;
      y = letter_at(tab, add26(x, off));
      return sub26(y, off);
   endfunction

   // Five plug pairs in order; the last pair that touches x wins.
   function automatic plug_hit_type plug_half(input logic [4:0] x,
                                              input logic [PLUG_W-1:0] w);
      plug_hit_type r;
      logic [4:0]   a;
      logic [4:0]   b;
      r = '0;
      for (int k = 0; k < 5; k++) begin
         a = w[10*k +: 5];
         b = w[10*k+5 +: 5];
         if (a < 5'd26 && b < 5'd26 && a != b) begin
            if (x == a) begin
               r.hit = 1'b1;
               r.val = b;
            end else if (x == b) begin
               r.hit = 1'b1;
               r.val = a;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] plug_map(input logic [4:0] x,
                                           input logic [PLUG_W-1:0] lo,
                                           input logic [PLUG_W-1:0] hi);
      plug_hit_type h1;
      plug_hit_type h2;
      h1 = plug_half(x, lo);
      h2 = plug_half(x, hi);
      if (h2.hit) begin
         return h2.val;
      end else if (h1.hit) begin
         return h1.val;
      end
      return x;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/enig_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma configuration registers
// APB-style register file holding rotor choice, ring settings and plugs.
// ----------------------------------------------------------------------------
module enig_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [enig_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [enig_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [enig_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready,
   output enig_pkg::enig_cfg_type                  cfg
);
   import enig_pkg::*;

   enig_cfg_type cfg_ff;
   enig_cfg_type cfg_in;
   logic         wr_en;
   logic [2:0]   reg_idx;
   logic [2:0]   rotor_val;
   logic [4:0]   ring_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign rotor_val  = (csr_pwdata[2:0] > 3'd4) ? 3'd4 : csr_pwdata[2:0];
   assign ring_val   = mod26(csr_pwdata[4:0]);

   // Write decode; rotor and ring values are normalized on the way in.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ROTOR_LEFT:   cfg_in.rotor_l = rotor_val;
            REG_ROTOR_MIDDLE: cfg_in.rotor_m = rotor_val;
            REG_ROTOR_RIGHT:  cfg_in.rotor_r = rotor_val;
            REG_RING_LEFT:    cfg_in.ring_l  = ring_val;
            REG_RING_MIDDLE:  cfg_in.ring_m  = ring_val;
            REG_RING_RIGHT:   cfg_in.ring_r  = ring_val;
            REG_PLUG_FIRST:   cfg_in.plug_lo = csr_pwdata[PLUG_W-1:0];
            REG_PLUG_SECOND:  cfg_in.plug_hi = csr_pwdata[PLUG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         cfg_ff.rotor_m <= 3'd1;
         cfg_ff.rotor_r <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         REG_ROTOR_LEFT:   csr_prdata = CSR_DATA_W'(cfg_ff.rotor_l);
         REG_ROTOR_MIDDLE: csr_prdata = CSR_DATA_W'(cfg_ff.rotor_m);
         REG_ROTOR_RIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.rotor_r);
         REG_RING_LEFT:    csr_prdata = CSR_DATA_W'(cfg_ff.ring_l);
         REG_RING_MIDDLE:  csr_prdata = CSR_DATA_W'(cfg_ff.ring_m);
         REG_RING_RIGHT:   csr_prdata = CSR_DATA_W'(cfg_ff.ring_r);
         REG_PLUG_FIRST:   csr_prdata = CSR_DATA_W'(cfg_ff.plug_lo);
         REG_PLUG_SECOND:  csr_prdata = CSR_DATA_W'(cfg_ff.plug_hi);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* hw/rtl/enig_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma front end
// Accepts requests, loads or steps the rotors and queues letters with their offsets.
// ----------------------------------------------------------------------------
module enig_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire enig_pkg::enig_cfg_type  cfg,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic                    opcode,
   input  wire logic [4:0]              letter_in,
   input  wire logic [4:0]              start_left,
   input  wire logic [4:0]              start_middle,
   input  wire logic [4:0]              start_right,
   input  wire logic                    queue_full,
   output logic                         push,
   output enig_pkg::enig_item_type      push_item
);
   import enig_pkg::*;

   logic [4:0] pos_l_ff, pos_m_ff, pos_r_ff;
   logic [4:0] pos_l_in, pos_m_in, pos_r_in;
   logic [4:0] step_l, step_m, step_r;
   logic [4:0] mid_turn, mid_before, right_turn;
   logic       mid_step;
   logic       accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   // Stepping: right always, middle on right turnover or double step,
   // left when the middle has just reached its turnover letter.
   assign mid_turn   = TURN_AFTER[cfg.rotor_m];
   assign right_turn = TURN_AFTER[cfg.rotor_r];
   assign mid_before = (mid_turn == 5'd0) ? 5'd25 : 5'(mid_turn - 5'd1);
   assign step_r     = inc26(pos_r_ff);
   assign mid_step   = (step_r == right_turn) || (pos_m_ff == mid_before);
   assign step_m     = mid_step ? inc26(pos_m_ff) : pos_m_ff;
   assign step_l     = (mid_step && step_m == mid_turn) ? inc26(pos_l_ff) : pos_l_ff;

   always_comb begin
      pos_l_in = pos_l_ff;
      pos_m_in = pos_m_ff;
      pos_r_in = pos_r_ff;
      if (accept) begin
         if (opcode == OP_LOAD) begin
            pos_l_in = mod26(start_left);
            pos_m_in = mod26(start_middle);
            pos_r_in = mod26(start_right);
         end else begin
            pos_l_in = step_l;
            pos_m_in = step_m;
            pos_r_in = step_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_l_ff <= '0;
         pos_m_ff <= '0;
         pos_r_ff <= '0;
      end else begin
         pos_l_ff <= pos_l_in;
         pos_m_ff <= pos_m_in;
         pos_r_ff <= pos_r_in;
      end
   end

   // Only encipher transactions go to the back end.
   assign push             = accept && (opcode == OP_ENCIPHER);
   assign push_item.letter = mod26(letter_in);
   assign push_item.off_l  = sub26(step_l, cfg.ring_l);
   assign push_item.off_m  = sub26(step_m, cfg.ring_m);
   assign push_item.off_r  = sub26(step_r, cfg.ring_r);
   assign push_item.win_l  = step_l;
   assign push_item.win_m  = step_m;
   assign push_item.win_r  = step_r;

endmodule
`default_nettype wire

/* hw/rtl/enig_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma item queue
// Short FIFO between the front end and the substitution pipeline.
// ----------------------------------------------------------------------------
module enig_fifo #(
   parameter int DEPTH = enig_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire enig_pkg::enig_item_type push_item,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         empty,
   output enig_pkg::enig_item_type      head
);
   import enig_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   enig_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/enig_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma substitution pipeline
// Plugboard, rotors forward, reflector, rotors inverse and plugboard again.
// ----------------------------------------------------------------------------
module enig_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire enig_pkg::enig_cfg_type  cfg,
   input  wire logic                    queue_empty,
   input  wire enig_pkg::enig_item_type head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output enig_pkg::enig_item_type      rsp_item
);
   import enig_pkg::*;

   localparam int STAGES = 4;

   enig_item_type st_ff [STAGES];
   enig_item_type st_in [STAGES];
   logic          vld_ff [STAGES];
   enig_item_type out_ff, out_in;
   logic          out_vld_ff;
   logic          advance;

   // The whole pipeline moves while the output register is free or taken.
   assign advance = !out_vld_ff || rsp_tready;
   assign pop     = advance && !queue_empty;

   always_comb begin
      // Plugboard in, then the right rotor forward.
      st_in[0]        = head;
      st_in[0].letter = rotor_pass(FWD_WIRING[cfg.rotor_r],
                                   plug_map(head.letter, cfg.plug_lo, cfg.plug_hi),
                                   head.off_r);
      // Middle and left rotors forward.
      st_in[1]        = st_ff[0];
      st_in[1].letter = rotor_pass(FWD_WIRING[cfg.rotor_l],
                                   rotor_pass(FWD_WIRING[cfg.rotor_m],
                                              st_ff[0].letter, st_ff[0].off_m),
                                   st_ff[0].off_l);
      // Reflector, then the left rotor inverse.
      st_in[2]        = st_ff[1];
      st_in[2].letter = rotor_pass(INV_WIRING[cfg.rotor_l],
                                   letter_at(REFL_B, st_ff[1].letter),
                                   st_ff[1].off_l);
      // Middle and right rotors inverse.
      st_in[3]        = st_ff[2];
      st_in[3].letter = rotor_pass(INV_WIRING[cfg.rotor_r],
                                   rotor_pass(INV_WIRING[cfg.rotor_m],
                                              st_ff[2].letter, st_ff[2].off_m),
                                   st_ff[2].off_r);
      // Plugboard out into the output register.
      out_in          = st_ff[STAGES-1];
      out_in.letter   = plug_map(st_ff[STAGES-1].letter, cfg.plug_lo, cfg.plug_hi);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= !queue_empty;
         for (int k = 1; k < STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_vld_ff <= vld_ff[STAGES-1];
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_item   = out_ff;

endmodule
`default_nettype wire

/* hw/rtl/enigma_rotor_cipher_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma I rotor cipher, top level
// Three-rotor Enigma I with reflector B and a ten-pair plugboard.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  req_*     in         tvalid / tready    tuser opcode, tdata letter and starts
//  rsp_*     out        tvalid / tready    tdata letter_out and rotor windows
//  csr_*     in         psel / penable     64-bit register writes and reads
//
//  One request is taken per clock while the queue has room; an accepted
//  encipher transaction passes through the queue, the pipeline stages and
//  the output register before rsp_tvalid rises.
//  A load transaction gives no response.
//  Reset is synchronous and restores the register defaults and position AAA.
//  A stalled output holds the pipeline; the queue then fills and req_tready
//  falls.
// ----------------------------------------------------------------------------
module enigma_rotor_cipher_top #(
   parameter int QUEUE_DEPTH = enig_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: letter_in[4:0], start_left[9:5], start_middle[14:10],
   //        start_right[19:15], zero pad[23:20]
   input  wire logic [23:0]                        req_tdata,
   // tuser: opcode[0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: letter_out[4:0], window_left[9:5], window_middle[14:10],
   //        window_right[19:15], zero pad[23:20]
   output logic      [23:0]                        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [enig_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [enig_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [enig_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready
);
   import enig_pkg::*;

   enig_cfg_type  cfg;
   enig_item_type push_item;
   enig_item_type head;
   enig_item_type rsp_item;
   logic          push, queue_full, queue_empty, pop;

   enig_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   enig_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .opcode       (req_tuser),
      .letter_in    (req_tdata[4:0]),
      .start_left   (req_tdata[9:5]),
      .start_middle (req_tdata[14:10]),
      .start_right  (req_tdata[19:15]),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item)
   );

   enig_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   enig_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tdata = {4'b0000, rsp_item.win_r, rsp_item.win_m, rsp_item.win_l,
                       rsp_item.letter};

endmodule
`default_nettype wire

/* hw/rtl/enig_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Enigma port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module enig_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [23:0]                     rsp_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic                            csr_psel,
   input wire logic                            csr_pready
);

   // No response survives a reset cycle.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Letter and windows are always proper letters.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] < 5'd26 && rsp_tdata[9:5] < 5'd26 &&
                     rsp_tdata[14:10] < 5'd26 && rsp_tdata[19:15] < 5'd26)
      else $error("response field out of range");

   // The register port never inserts wait states.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port not ready");

endmodule

bind enigma_rotor_cipher_top enig_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tdata   (rsp_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .csr_psel    (csr_psel),
   .csr_pready  (csr_pready)
);
`default_nettype wire
